// ===== rtl/core/ssmm_pkg.sv =====
package ssmm_pkg;

    // default widths of the sample and of the set counters
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // fixed field widths of the configuration and result
    localparam int CFG_BITS    = 16;
    localparam int TOTAL_BITS  = 32;
    localparam int MEAN_BITS   = 24;
    localparam int MEDIAN_BITS = 17;
    localparam int MODE_BITS   = 16;
    localparam int FREQ_BITS   = 16;
    localparam int STATUS_BITS = 2;

    // mean divider: magnitude of the sum with eight fraction bits appended
    localparam int FRAC_BITS    = 8;
    localparam int DIV_BITS     = TOTAL_BITS + FRAC_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    // saturation bounds of the mean, as quotient magnitudes
    localparam logic [DIV_BITS-1:0] MEAN_POS_LIMIT = DIV_BITS'((64'd1 << (MEAN_BITS - 1)) - 1);
    localparam logic [DIV_BITS-1:0] MEAN_NEG_LIMIT = DIV_BITS'(64'd1 << (MEAN_BITS - 1));
    localparam logic [MEAN_BITS-1:0] MEAN_POS_SAT  = {1'b0, {(MEAN_BITS-1){1'b1}}};
    localparam logic [MEAN_BITS-1:0] MEAN_NEG_SAT  = {1'b1, {(MEAN_BITS-1){1'b0}}};

    // summary queue between front and back
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // result stream packing
    localparam int M_DATA_USED = TOTAL_BITS + MEAN_BITS + MEDIAN_BITS + MODE_BITS + FREQ_BITS;
    localparam int M_DATA_BITS = ((M_DATA_USED + 7) / 8) * 8;
    localparam int M_DATA_PAD  = M_DATA_BITS - M_DATA_USED;
    localparam int M_USER_BITS = STATUS_BITS + 1;

    typedef enum logic [STATUS_BITS-1:0] {
        MS_UNSORTED = 2'd0,
        MS_UNIQUE   = 2'd1,
        MS_SINGLE   = 2'd2,
        MS_SEVERAL  = 2'd3
    } mode_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_DIVIDE
    } back_state_t;

    // one finished set, handed from front to back
    typedef struct packed {
        logic [TOTAL_BITS-1:0]  total;
        logic [MEDIAN_BITS-1:0] median_twice;
        logic                   is_sorted;
        logic [MODE_BITS-1:0]   mode_value;
        logic [FREQ_BITS-1:0]   mode_frequency;
        mode_status_t           mode_status;
        logic [CFG_BITS-1:0]    count;
    } set_rec_t;

    // one result beat
    typedef struct packed {
        logic [TOTAL_BITS-1:0]  total;
        logic [MEAN_BITS-1:0]   mean_q8;
        logic [MEDIAN_BITS-1:0] median_twice;
        logic                   is_sorted;
        logic [MODE_BITS-1:0]   mode_value;
        logic [FREQ_BITS-1:0]   mode_frequency;
        mode_status_t           mode_status;
    } result_t;

endpackage

// ===== rtl/core/ssmm_front.sv =====
module ssmm_front #(
    parameter int SAMPLE_BITS = ssmm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = ssmm_pkg::COUNT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ssmm_pkg::CFG_BITS-1:0]   cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic signed [SAMPLE_BITS-1:0]   sample,
    input  logic                            q_full,
    output logic                            q_push,
    output ssmm_pkg::set_rec_t              q_rec
);

    logic [ssmm_pkg::CFG_BITS-1:0]   count_reg;
    logic [ssmm_pkg::TOTAL_BITS-1:0] sum_reg, sum_next;
    logic [COUNT_BITS-1:0]           pos_reg, idx;
    logic signed [SAMPLE_BITS-1:0]   fm_reg, fm_next;
    logic signed [SAMPLE_BITS-1:0]   sm_reg, sm_next;
    logic                            have_prev_reg;
    logic                            order_ok_reg, ok_next;
    logic signed [SAMPLE_BITS-1:0]   run_value_reg, rv_next;
    logic [COUNT_BITS-1:0]           run_len_reg, rl_next;
    logic [COUNT_BITS-1:0]           best_len_reg, bl_next;
    logic signed [SAMPLE_BITS-1:0]   best_value_reg, bv_next;
    logic [COUNT_BITS-1:0]           tie_reg, tc_next;

    logic [ssmm_pkg::CFG_BITS-1:0]   n, mid1, mid2;
    logic                            fire, last;
    logic [COUNT_BITS-1:0]           bl_fin;
    logic signed [SAMPLE_BITS-1:0]   bv_fin;
    logic                            tc_one;
    ssmm_pkg::mode_status_t          status;

    assign s_tready = !q_full;
    assign fire     = s_tvalid && !q_full;
    assign q_push   = fire && last;

    // set size, middle indexes and sample index
    always_comb begin
        n    = (count_reg == '0) ? ssmm_pkg::CFG_BITS'(1) : count_reg;
        mid1 = ssmm_pkg::CFG_BITS'((17'(n) + 17'd1) >> 1);
        mid2 = n[0] ? mid1 : ssmm_pkg::CFG_BITS'((n >> 1) + ssmm_pkg::CFG_BITS'(1));
        idx  = pos_reg + COUNT_BITS'(1);
        last = (32'(idx) == 32'(n));
    end

    // per-sample update of sum, middles, order and runs
    always_comb begin
        sum_next = sum_reg + 32'(sample);
        fm_next  = (32'(idx) == 32'(mid1)) ? sample : fm_reg;
        sm_next  = (32'(idx) == 32'(mid2)) ? sample : sm_reg;
        ok_next  = order_ok_reg;
        rv_next  = run_value_reg;
        rl_next  = run_len_reg;
        bl_next  = best_len_reg;
        bv_next  = best_value_reg;
        tc_next  = tie_reg;
        if (!have_prev_reg) begin
            rv_next = sample;
            rl_next = COUNT_BITS'(1);
            bl_next = COUNT_BITS'(1);
            bv_next = sample;
            tc_next = COUNT_BITS'(1);
        end else begin
            if (sample < run_value_reg) begin
                ok_next = 1'b0;
            end
            if (sample == run_value_reg) begin
                rl_next = run_len_reg + COUNT_BITS'(1);
            end else begin
                if (run_len_reg > best_len_reg) begin
                    bl_next = run_len_reg;
                    bv_next = run_value_reg;
                    tc_next = COUNT_BITS'(1);
                end else if (run_len_reg == best_len_reg) begin
                    tc_next = tie_reg + COUNT_BITS'(1);
                end
                rv_next = sample;
                rl_next = COUNT_BITS'(1);
            end
        end
    end

    // close the open run and summarize the set
    always_comb begin
        if (rl_next > bl_next) begin
            bl_fin = rl_next;
            bv_fin = rv_next;
            tc_one = 1'b1;
        end else if (rl_next == bl_next) begin
            bl_fin = bl_next;
            bv_fin = bv_next;
            tc_one = (tc_next == '0);
        end else begin
            bl_fin = bl_next;
            bv_fin = bv_next;
            tc_one = (tc_next == COUNT_BITS'(1));
        end

        priority if (!ok_next) begin
            status = ssmm_pkg::MS_UNSORTED;
        end else if (bl_fin <= COUNT_BITS'(1)) begin
            status = ssmm_pkg::MS_UNIQUE;
        end else if (tc_one) begin
            status = ssmm_pkg::MS_SINGLE;
        end else begin
            status = ssmm_pkg::MS_SEVERAL;
        end

        q_rec.total          = sum_next;
        q_rec.median_twice   = ok_next ? ssmm_pkg::MEDIAN_BITS'(33'(fm_next) + 33'(sm_next))
                                       : '0;
        q_rec.is_sorted      = ok_next;
        q_rec.mode_value     = (status == ssmm_pkg::MS_SINGLE) ?
                               ssmm_pkg::MODE_BITS'(32'(bv_fin)) : '0;
        q_rec.mode_frequency = ok_next ? ssmm_pkg::FREQ_BITS'(32'(bl_fin)) : '0;
        q_rec.mode_status    = status;
        q_rec.count          = n;
    end

    // configuration register and set state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= ssmm_pkg::CFG_BITS'(1);
            sum_reg        <= '0;
            pos_reg        <= '0;
            fm_reg         <= '0;
            sm_reg         <= '0;
            have_prev_reg  <= 1'b0;
            order_ok_reg   <= 1'b1;
            run_value_reg  <= '0;
            run_len_reg    <= '0;
            best_len_reg   <= '0;
            best_value_reg <= '0;
            tie_reg        <= '0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (fire) begin
                if (last) begin
                    sum_reg        <= '0;
                    pos_reg        <= '0;
                    fm_reg         <= '0;
                    sm_reg         <= '0;
                    have_prev_reg  <= 1'b0;
                    order_ok_reg   <= 1'b1;
                    run_value_reg  <= '0;
                    run_len_reg    <= '0;
                    best_len_reg   <= '0;
                    best_value_reg <= '0;
                    tie_reg        <= '0;
                end else begin
                    sum_reg        <= sum_next;
                    pos_reg        <= idx;
                    fm_reg         <= fm_next;
                    sm_reg         <= sm_next;
                    have_prev_reg  <= 1'b1;
                    order_ok_reg   <= ok_next;
                    run_value_reg  <= rv_next;
                    run_len_reg    <= rl_next;
                    best_len_reg   <= bl_next;
                    best_value_reg <= bv_next;
                    tie_reg        <= tc_next;
                end
            end
        end
    end

    // a set that ends starts the next one from scratch
    a_set_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> (pos_reg == '0) && !have_prev_reg && order_ok_reg)
        else $error("set state not cleared after last sample");

    // a beat that does not end the set leaves a previous sample behind
    a_prev_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !last) |=> have_prev_reg)
        else $error("previous sample lost inside a set");

endmodule

// ===== rtl/core/ssmm_fifo.sv =====
module ssmm_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ssmm_pkg::set_rec_t din,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output ssmm_pkg::set_rec_t dout
);

    ssmm_pkg::set_rec_t                   mem [ssmm_pkg::QUEUE_DEPTH];
    logic [ssmm_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg;
    logic [ssmm_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg;
    logic [ssmm_pkg::QUEUE_PTR_BITS:0]    fill_reg;

    assign full  = (fill_reg == (ssmm_pkg::QUEUE_PTR_BITS + 1)'(ssmm_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + ssmm_pkg::QUEUE_PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + ssmm_pkg::QUEUE_PTR_BITS'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (ssmm_pkg::QUEUE_PTR_BITS + 1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (ssmm_pkg::QUEUE_PTR_BITS + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("summary queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("summary queue underflow");

endmodule

// ===== rtl/core/ssmm_div.sv =====
module ssmm_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ssmm_pkg::DIV_BITS-1:0]     dividend,
    input  logic [ssmm_pkg::CFG_BITS-1:0]     divisor,
    output logic                              done,
    output logic [ssmm_pkg::DIV_BITS-1:0]     quotient
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [ssmm_pkg::DIV_CNT_BITS-1:0]   cnt_reg;
    logic [ssmm_pkg::CFG_BITS-1:0]       rem_reg, rem_next;
    logic [ssmm_pkg::CFG_BITS-1:0]       dsr_reg;
    logic [ssmm_pkg::DIV_BITS-1:0]       quo_reg;
    logic [ssmm_pkg::CFG_BITS:0]         trial;
    logic                                ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[ssmm_pkg::DIV_BITS-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? ssmm_pkg::CFG_BITS'(trial - {1'b0, dsr_reg})
                      : ssmm_pkg::CFG_BITS'(trial);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + ssmm_pkg::DIV_CNT_BITS'(1);
            if (cnt_reg == ssmm_pkg::DIV_CNT_BITS'(ssmm_pkg::DIV_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath, quotient bits replace dividend bits from the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ssmm_pkg::DIV_BITS-2:0], ge};
        end
    end

    a_done_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !done_reg && busy_reg)
        else $error("divider did not restart");

endmodule

// ===== rtl/core/ssmm_back.sv =====
module ssmm_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  ssmm_pkg::set_rec_t q_rec,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ssmm_pkg::result_t  result
);

    ssmm_pkg::back_state_t               state_reg, state_next;
    ssmm_pkg::set_rec_t                  rec_reg;
    ssmm_pkg::result_t                   out_reg;
    logic                                m_tvalid_reg;
    logic                                div_start, div_done, load_out;
    logic [ssmm_pkg::TOTAL_BITS-1:0]     mag;
    logic [ssmm_pkg::DIV_BITS-1:0]       quo, quo_neg;
    logic [ssmm_pkg::MEAN_BITS-1:0]      mean;

    assign m_tvalid = m_tvalid_reg;
    assign result   = out_reg;

    // magnitude of the sum, scaled by 256, goes to the divider
    assign mag = q_rec.total[ssmm_pkg::TOTAL_BITS-1] ? (~q_rec.total + ssmm_pkg::TOTAL_BITS'(1))
                                                     : q_rec.total;

    ssmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({mag, ssmm_pkg::FRAC_BITS'(0)}),
        .divisor  (q_rec.count),
        .done     (div_done),
        .quotient (quo)
    );

    // signed, saturated mean from the magnitude quotient
    always_comb begin
        quo_neg = ~quo + ssmm_pkg::DIV_BITS'(1);
        if (rec_reg.total[ssmm_pkg::TOTAL_BITS-1]) begin
            mean = (quo > ssmm_pkg::MEAN_NEG_LIMIT) ? ssmm_pkg::MEAN_NEG_SAT
                                                    : quo_neg[ssmm_pkg::MEAN_BITS-1:0];
        end else begin
            mean = (quo > ssmm_pkg::MEAN_POS_LIMIT) ? ssmm_pkg::MEAN_POS_SAT
                                                    : quo[ssmm_pkg::MEAN_BITS-1:0];
        end
    end

    // sequencer: take a summary, divide, hand the result to the output register
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ssmm_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    div_start  = 1'b1;
                    state_next = ssmm_pkg::BK_DIVIDE;
                end
            end
            ssmm_pkg::BK_DIVIDE: begin
                if (div_done && (!m_tvalid_reg || m_tready)) begin
                    load_out   = 1'b1;
                    state_next = ssmm_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = ssmm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ssmm_pkg::BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // summary and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rec_reg <= q_rec;
        end
        if (load_out) begin
            out_reg.total          <= rec_reg.total;
            out_reg.mean_q8        <= mean;
            out_reg.median_twice   <= rec_reg.median_twice;
            out_reg.is_sorted      <= rec_reg.is_sorted;
            out_reg.mode_value     <= rec_reg.mode_value;
            out_reg.mode_frequency <= rec_reg.mode_frequency;
            out_reg.mode_status    <= rec_reg.mode_status;
        end
    end

    a_wait_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssmm_pkg::BK_DIVIDE && !div_done) |=> state_reg == ssmm_pkg::BK_DIVIDE)
        else $error("back end left division early");

endmodule

// ===== rtl/core/sorted_stream_mean_median_mode_unit.sv =====
// channel  | dir | ports                         | contents
// sample   | in  | s_tvalid s_tready s_tdata     | sample
// result   | out | m_tvalid m_tready m_tdata     | total, mean_q8, median_twice,
//          |     | m_tuser                       | mode_value, mode_frequency;
//          |     |                               | is_sorted, mode_status
// config   | in  | cfg_we cfg_wdata              | sample_count
//
// one sample beat per cycle while s_tready is high; the front updates sum,
// middles and runs for each beat; the result of a set waits for the
// one-bit-per-cycle mean divider (40 steps) in the back end
// a two-entry summary queue lets the front keep taking samples of later sets
// while the back divides; s_tready drops only when both entries are waiting
// synchronous active-low reset clears all set state and sets sample_count to 1
module sorted_stream_mean_median_mode_unit #(
    parameter int SAMPLE_BITS = ssmm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = ssmm_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ssmm_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // total, mean_q8, median_twice, mode_value, mode_frequency, zero pad
    output logic [ssmm_pkg::M_DATA_BITS-1:0]    m_tdata,
    // is_sorted, mode_status
    output logic [ssmm_pkg::M_USER_BITS-1:0]    m_tuser
);

    logic                          q_full, q_empty, q_push, q_pop;
    ssmm_pkg::set_rec_t            rec_in, rec_out;
    ssmm_pkg::result_t             result;
    logic signed [SAMPLE_BITS-1:0] sample;

    assign sample = s_tdata[SAMPLE_BITS-1:0];

    ssmm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (sample),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (rec_in)
    );

    ssmm_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (rec_in),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .dout    (rec_out)
    );

    ssmm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rec    (rec_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    // result beat packing, lowest field first
    assign m_tdata = {ssmm_pkg::M_DATA_PAD'(0), result.mode_frequency, result.mode_value,
                      result.median_twice, result.mean_q8, result.total};
    assign m_tuser = {result.mode_status, result.is_sorted};

endmodule
